@@ rtl/bresenham_line_rasterizer_top_macros.svh @@
// Assertion macros shared by the rasterizer modules.
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define BLR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

`define BLR_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define BLR_ASSERT(lbl, clk, rstn, prop)

`define BLR_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ rtl/blr_pkg.sv @@
`default_nettype none

package blr_pkg;

    localparam int C_COORD_BITS = 9;
    localparam int C_COLOUR_BITS = 16;
    localparam int C_ADDR_BITS = 32;
    localparam int C_ERR_BITS = C_COORD_BITS + 2;

    // Command queue between the front and the back.
    localparam int C_Q_DEPTH = 2;
    localparam int C_Q_PTR_BITS = (C_Q_DEPTH > 1) ? $clog2(C_Q_DEPTH) : 1;
    localparam int C_Q_CNT_BITS = $clog2(C_Q_DEPTH + 1);

    // Configuration space.
    localparam int C_PADDR_BITS = 3;
    localparam logic [C_PADDR_BITS-1:0] C_ADDR_FRAME_BASE = 3'd0;
    localparam logic [C_ADDR_BITS-1:0] C_FRAME_BASE_RESET = 32'hC800_0000;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic [C_COORD_BITS-1:0]  x_start;
        logic [C_COORD_BITS-1:0]  y_start;
        logic [C_COORD_BITS-1:0]  x_end;
        logic [C_COORD_BITS-1:0]  y_end;
        logic [C_COLOUR_BITS-1:0] colour_in;
    } t_in_item;

    typedef struct packed {
        logic [C_COORD_BITS-1:0]  pixel_x;
        logic [C_COORD_BITS-1:0]  pixel_y;
        logic [C_ADDR_BITS-1:0]   pixel_address;
        logic [C_COLOUR_BITS-1:0] colour_out;
        logic                     last;
    } t_out_item;

    // A classified command: a prepared line set-up, or an advance request.
    typedef struct packed {
        t_op                      op;
        logic                     steep;
        logic [C_COORD_BITS-1:0]  major_pos;
        logic [C_COORD_BITS-1:0]  major_stop;
        logic [C_COORD_BITS-1:0]  minor_pos;
        logic                     minor_down;
        logic [C_COORD_BITS-1:0]  delta_major;
        logic [C_COORD_BITS-1:0]  delta_minor;
        logic signed [C_ERR_BITS-1:0] error_init;
        logic [C_COLOUR_BITS-1:0] colour;
    } t_cmd;

    // Occupancy flags of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

@@ rtl/blr_front.sv @@
`default_nettype none

// Classifies incoming items and prepares the Bresenham set-up for start items.
module blr_front (
    input  wire blr_pkg::t_in_item i_item,
    output blr_pkg::t_cmd          o_cmd
);

    localparam int CB = blr_pkg::C_COORD_BITS;

    logic [CB-1:0] dx;
    logic [CB-1:0] dy;
    logic          steep;
    logic [CB-1:0] a0;
    logic [CB-1:0] b0;
    logic [CB-1:0] a1;
    logic [CB-1:0] b1;
    logic          swap_ends;
    logic [CB-1:0] maj_lo;
    logic [CB-1:0] maj_hi;
    logic [CB-1:0] min_lo;
    logic [CB-1:0] min_hi;
    logic [CB-1:0] d_major;
    logic [CB-1:0] d_minor;
    logic [CB+1:0] half_major;

    always_comb begin
        dx = (i_item.x_start > i_item.x_end) ? (i_item.x_start - i_item.x_end)
                                             : (i_item.x_end - i_item.x_start);
        dy = (i_item.y_start > i_item.y_end) ? (i_item.y_start - i_item.y_end)
                                             : (i_item.y_end - i_item.y_start);
        steep = (dy > dx);

        if (steep) begin
            a0 = i_item.y_start;
            b0 = i_item.x_start;
            a1 = i_item.y_end;
            b1 = i_item.x_end;
        end else begin
            a0 = i_item.x_start;
            b0 = i_item.y_start;
            a1 = i_item.x_end;
            b1 = i_item.y_end;
        end

        // Walk the major axis upwards.
        swap_ends = (a0 > a1);
        maj_lo = swap_ends ? a1 : a0;
        maj_hi = swap_ends ? a0 : a1;
        min_lo = swap_ends ? b1 : b0;
        min_hi = swap_ends ? b0 : b1;

        d_major = steep ? dy : dx;
        d_minor = steep ? dx : dy;
        half_major = {3'b000, d_major[CB-1:1]};

        o_cmd.op          = i_item.op;
        o_cmd.steep       = steep;
        o_cmd.major_pos   = maj_lo;
        o_cmd.major_stop  = maj_hi;
        o_cmd.minor_pos   = min_lo;
        o_cmd.minor_down  = (min_lo > min_hi);
        o_cmd.delta_major = d_major;
        o_cmd.delta_minor = d_minor;
        o_cmd.error_init  = signed'(-half_major);
        o_cmd.colour      = i_item.colour_in;
    end

endmodule

`default_nettype wire

@@ rtl/blr_queue.sv @@
`default_nettype none

`include "bresenham_line_rasterizer_top_macros.svh"

// Short command queue that decouples the front from the back.
module blr_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_wr_en,
    input  wire blr_pkg::t_cmd    i_wr_data,
    input  wire                   i_rd_en,
    output blr_pkg::t_cmd         o_rd_data,
    output blr_pkg::t_q_status    o_status
);

    localparam int D  = blr_pkg::C_Q_DEPTH;
    localparam int PB = blr_pkg::C_Q_PTR_BITS;
    localparam int CB = blr_pkg::C_Q_CNT_BITS;
    localparam logic [PB-1:0] LAST_PTR = PB'(D - 1);
    localparam logic [CB-1:0] FULL_CNT = CB'(D);

    blr_pkg::t_cmd r_mem [D];
    logic [PB-1:0] r_wr_ptr;
    logic [PB-1:0] n_wr_ptr;
    logic [PB-1:0] r_rd_ptr;
    logic [PB-1:0] n_rd_ptr;
    logic [CB-1:0] r_count;
    logic [CB-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr_en) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr_en && !i_rd_en) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr_en && i_rd_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data       = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == FULL_CNT);
    assign o_status.empty  = (r_count == '0);

    `BLR_ASSERT_NEVER(a_q_overflow, i_clk, i_rst_n, i_wr_en && !i_rd_en && (r_count == FULL_CNT))
    `BLR_ASSERT_NEVER(a_q_underflow, i_clk, i_rst_n, i_rd_en && (r_count == '0))

endmodule

`default_nettype wire

@@ rtl/blr_back.sv @@
`default_nettype none

`include "bresenham_line_rasterizer_top_macros.svh"

// Holds the line being drawn and turns advance commands into pixels.
module blr_back #(
    parameter int ROW_SHIFT = 10
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire blr_pkg::t_q_status  i_q_status,
    input  wire blr_pkg::t_cmd       i_cmd,
    output logic                     o_cmd_take,
    input  wire [31:0]               i_frame_base,
    input  wire                      i_pop,
    output blr_pkg::t_out_item       o_item,
    output logic                     o_empty
);

    localparam int CB = blr_pkg::C_COORD_BITS;
    localparam int EB = blr_pkg::C_ERR_BITS;
    localparam int AB = blr_pkg::C_ADDR_BITS;

    logic                   r_busy;
    logic                   n_busy;
    logic                   r_steep;
    logic                   n_steep;
    logic [CB-1:0]          r_major_pos;
    logic [CB-1:0]          n_major_pos;
    logic [CB-1:0]          r_major_stop;
    logic [CB-1:0]          n_major_stop;
    logic [CB-1:0]          r_minor_pos;
    logic [CB-1:0]          n_minor_pos;
    logic                   r_minor_down;
    logic                   n_minor_down;
    logic [CB-1:0]          r_delta_major;
    logic [CB-1:0]          n_delta_major;
    logic [CB-1:0]          r_delta_minor;
    logic [CB-1:0]          n_delta_minor;
    logic signed [EB-1:0]   r_error;
    logic signed [EB-1:0]   n_error;
    logic [15:0]            r_colour;
    logic [15:0]            n_colour;
    logic                   r_out_valid;
    logic                   n_out_valid;
    blr_pkg::t_out_item     r_out;
    blr_pkg::t_out_item     n_out;

    logic                   slot_free;
    logic                   emit;
    logic                   is_last;
    logic [CB-1:0]          px;
    logic [CB-1:0]          py;
    logic [AB-1:0]          row_term;
    logic [AB-1:0]          col_term;
    logic signed [EB-1:0]   err_add;

    always_comb begin
        slot_free  = !r_out_valid || i_pop;
        o_cmd_take = slot_free && !i_q_status.empty;
        emit       = o_cmd_take && (i_cmd.op == blr_pkg::OP_ADVANCE) && r_busy;

        px       = r_steep ? r_minor_pos : r_major_pos;
        py       = r_steep ? r_major_pos : r_minor_pos;
        is_last  = (r_major_pos == r_major_stop);
        row_term = AB'({{AB{1'b0}}, py} << ROW_SHIFT);
        col_term = {{(AB - CB - 1){1'b0}}, px, 1'b0};
        err_add  = r_error + signed'({2'b00, r_delta_minor});

        n_busy        = r_busy;
        n_steep       = r_steep;
        n_major_pos   = r_major_pos;
        n_major_stop  = r_major_stop;
        n_minor_pos   = r_minor_pos;
        n_minor_down  = r_minor_down;
        n_delta_major = r_delta_major;
        n_delta_minor = r_delta_minor;
        n_error       = r_error;
        n_colour      = r_colour;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !i_pop;

        if (o_cmd_take && (i_cmd.op == blr_pkg::OP_START)) begin
            n_busy        = 1'b1;
            n_steep       = i_cmd.steep;
            n_major_pos   = i_cmd.major_pos;
            n_major_stop  = i_cmd.major_stop;
            n_minor_pos   = i_cmd.minor_pos;
            n_minor_down  = i_cmd.minor_down;
            n_delta_major = i_cmd.delta_major;
            n_delta_minor = i_cmd.delta_minor;
            n_error       = i_cmd.error_init;
            n_colour      = i_cmd.colour;
        end else if (emit) begin
            n_out.pixel_x       = px;
            n_out.pixel_y       = py;
            n_out.pixel_address = i_frame_base + row_term + col_term;
            n_out.colour_out    = r_colour;
            n_out.last          = is_last;
            n_out_valid         = 1'b1;
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_major_pos = r_major_pos + 1'b1;
                if (err_add >= 0) begin
                    n_minor_pos = r_minor_down ? (r_minor_pos - 1'b1) : (r_minor_pos + 1'b1);
                    n_error     = err_add - signed'({2'b00, r_delta_major});
                end else begin
                    n_error = err_add;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steep       <= n_steep;
        r_major_pos   <= n_major_pos;
        r_major_stop  <= n_major_stop;
        r_minor_pos   <= n_minor_pos;
        r_minor_down  <= n_minor_down;
        r_delta_major <= n_delta_major;
        r_delta_minor <= n_delta_minor;
        r_error       <= n_error;
        r_colour      <= n_colour;
        r_out         <= n_out;
    end

    assign o_item  = r_out;
    assign o_empty = !r_out_valid;

    `BLR_ASSERT(a_out_held, i_clk, i_rst_n, (r_out_valid && !i_pop) |=> r_out_valid)
    `BLR_ASSERT(a_last_ends_line, i_clk, i_rst_n, (emit && is_last) |=> !r_busy)

endmodule

`default_nettype wire

@@ rtl/bresenham_line_rasterizer_top.sv @@
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------
// item in  | input     | push / full          | i_item (op, endpoints, colour)
// pixel out| output    | pop / empty          | o_item (x, y, address, colour, last)
// config   | input     | psel/penable/pready  | paddr, pwdata, prdata (frame_base)
//
// One item can be transferred in every cycle while full is low, and one pixel out in every
// cycle while advances are queued and pixels are popped; the back end does one error add,
// one compare and one subtract per advance, and registers each advance's pixel for output.
// Reset is synchronous and active low; it empties the queue, drops any line in
// progress and sets frame_base to 0xC8000000.
// full rises only when both queue entries are held, which happens only while a result waits.
module bresenham_line_rasterizer_top #(
    parameter int ROW_SHIFT = 10
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  wire blr_pkg::t_in_item               i_item,
    output logic                                 empty,
    input  wire                                  pop,
    output blr_pkg::t_out_item                   o_item,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [blr_pkg::C_PADDR_BITS-1:0]      paddr,
    input  wire [31:0]                           pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // The frame base is the only configuration register.
    logic [31:0] r_frame_base;
    logic        cfg_write;

    // Front end: every transfer is classified and, for a start, the line set-up
    // (steepness, end ordering, deltas and initial error) is prepared here.
    blr_pkg::t_cmd      front_cmd;
    blr_pkg::t_cmd      queue_cmd;
    blr_pkg::t_q_status q_status;
    logic               q_write;
    logic               q_take;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= blr_pkg::C_FRAME_BASE_RESET;
        end else if (cfg_write && (paddr == blr_pkg::C_ADDR_FRAME_BASE)) begin
            r_frame_base <= pwdata;
        end
    end

    always_comb begin
        if (paddr == blr_pkg::C_ADDR_FRAME_BASE) begin
            prdata = r_frame_base;
        end else begin
            prdata = '0;
        end
    end

    assign full    = q_status.full;
    assign q_write = push && !q_status.full;

    blr_front u_front (
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    // The queue lets the front keep taking items while the back waits for the
    // consumer to take a pixel.
    blr_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_write),
        .i_wr_data (front_cmd),
        .i_rd_en   (q_take),
        .o_rd_data (queue_cmd),
        .o_status  (q_status)
    );

    // Back end: owns the line state; an advance while no line is active is
    // consumed silently, and a start always replaces the current line.
    blr_back #(
        .ROW_SHIFT (ROW_SHIFT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_cmd        (queue_cmd),
        .o_cmd_take   (q_take),
        .i_frame_base (r_frame_base),
        .i_pop        (pop),
        .o_item       (o_item),
        .o_empty      (empty)
    );

endmodule

`default_nettype wire
